// ----- rtl/jsu_pkg.sv -----
// Shared types for the JSON string unescaper: result kinds, error codes and
// the result bundle passed from the parser to the output stage.
// No dependencies.
package jsu_pkg;

  // Kind of one result.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Error codes reported with an error result.
  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_BAD_OPEN = 4'd1,
    ERR_BAD_HEX  = 4'd2,
    ERR_BAD_LOW  = 4'd3,
    ERR_UNPAIRED = 4'd4,
    ERR_BAD_ESC  = 4'd5,
    ERR_CTRL     = 4'd6,
    ERR_UTF8     = 4'd7,
    ERR_NO_U     = 4'd8,
    ERR_EOF      = 4'd9
  } err_t;

  // All results caused by one input byte: up to four bytes of data, or one
  // end or error result. last_idx is the index of the final result.
  typedef struct packed {
    logic [1:0]      last_idx;
    kind_t           kind;
    err_t            err;
    logic [3:0][7:0] bytes;
  } bundle_t;

endpackage

// ----- rtl/jsu_front.sv -----
// Parser front end of the JSON string unescaper: string state machine,
// escape and \u decoding, UTF-8 checks. Produces at most one result bundle per byte.
// Depends on jsu_pkg.
module jsu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             allow_legacy,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             end_of_input,
  output logic             push,
  output jsu_pkg::bundle_t bundle
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_STR  = 3'd1,
    M_ESC  = 3'd2,
    M_CONT = 3'd3,
    M_HEX1 = 3'd4,
    M_BSL  = 3'd5,
    M_LU   = 3'd6,
    M_HEX2 = 3'd7
  } mode_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UPPER_U = 8'h55;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  mode_t       mode, mode_next;
  logic        quote_single, quote_single_next;
  logic [11:0] hex_accum, hex_accum_next;
  logic [1:0]  hex_digits, hex_digits_next;
  logic [9:0]  high_surr, high_surr_next;
  logic [1:0]  cont_left, cont_left_next;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] hex_word;
  logic [20:0] pair_rune;

  logic        res_err, res_end, res_byte, res_rune, go_idle;
  err_t        err_val;
  logic [7:0]  byte_val;
  logic [20:0] rune_val;
  logic [7:0]  close_quote;

  // Hex digit decode of the incoming byte.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_val = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_word    = {hex_accum, hex_val};
  assign pair_rune   = {1'b0, high_surr, hex_word[9:0]} + 21'h10000;
  assign close_quote = quote_single ? CH_SQUOTE : CH_DQUOTE;

  // Next state and result selection for one accepted byte.
  always_comb begin
    mode_next         = mode;
    quote_single_next = quote_single;
    hex_accum_next    = hex_accum;
    hex_digits_next   = hex_digits;
    high_surr_next    = high_surr;
    cont_left_next    = cont_left;
    res_err  = 1'b0;
    res_end  = 1'b0;
    res_byte = 1'b0;
    res_rune = 1'b0;
    go_idle  = 1'b0;
    err_val  = ERR_NONE;
    byte_val = 8'd0;
    rune_val = 21'd0;

    if (end_of_input) begin
      if (mode == M_IDLE) begin
        go_idle = 1'b1;
      end else begin
        res_err = 1'b1;
        err_val = ERR_EOF;
      end
    end else begin
      unique case (mode)
        M_STR: begin
          if (in_byte == close_quote) begin
            res_end = 1'b1;
            go_idle = 1'b1;
          end else if (in_byte == CH_BSLASH) begin
            mode_next = M_ESC;
          end else if ((in_byte < CH_SPACE || in_byte == 8'hff) && !allow_legacy) begin
            res_err = 1'b1;
            err_val = ERR_CTRL;
          end else if (!in_byte[7]) begin
            res_byte = 1'b1;
            byte_val = in_byte;
          end else if (in_byte[7:5] == 3'b110) begin
            cont_left_next = 2'd1;
            mode_next      = M_CONT;
            res_byte       = 1'b1;
            byte_val       = in_byte;
          end else if (in_byte[7:4] == 4'b1110) begin
            cont_left_next = 2'd2;
            mode_next      = M_CONT;
            res_byte       = 1'b1;
            byte_val       = in_byte;
          end else if (in_byte[7:3] == 5'b11110) begin
            cont_left_next = 2'd3;
            mode_next      = M_CONT;
            res_byte       = 1'b1;
            byte_val       = in_byte;
          end else begin
            res_err = 1'b1;
            err_val = ERR_UTF8;
          end
        end
        M_CONT: begin
          if (in_byte[7:6] != 2'b10) begin
            res_err = 1'b1;
            err_val = ERR_UTF8;
          end else begin
            cont_left_next = cont_left - 2'd1;
            if (cont_left == 2'd1) begin
              mode_next = M_STR;
            end
            res_byte = 1'b1;
            byte_val = in_byte;
          end
        end
        M_ESC: begin
          if (in_byte == CH_U || (in_byte == CH_UPPER_U && allow_legacy)) begin
            mode_next       = M_HEX1;
            hex_accum_next  = 12'd0;
            hex_digits_next = 2'd0;
          end else begin
            mode_next = M_STR;
            res_byte  = 1'b1;
            case (in_byte)
              CH_DQUOTE, CH_BSLASH, CH_SLASH: byte_val = in_byte;
              CH_B: byte_val = 8'h08;
              CH_F: byte_val = 8'h0c;
              CH_N: byte_val = CH_LF;
              CH_R: byte_val = CH_CR;
              CH_T: byte_val = CH_TAB;
              CH_SQUOTE: begin
                if (allow_legacy) begin
                  byte_val = CH_SQUOTE;
                end else begin
                  res_byte = 1'b0;
                  res_err  = 1'b1;
                  err_val  = ERR_BAD_ESC;
                end
              end
              default: begin
                res_byte = 1'b0;
                res_err  = 1'b1;
                err_val  = ERR_BAD_ESC;
              end
            endcase
          end
        end
        M_HEX1, M_HEX2: begin
          if (!hex_ok) begin
            res_err = 1'b1;
            err_val = ERR_BAD_HEX;
          end else if (hex_digits != 2'd3) begin
            hex_accum_next  = hex_word[11:0];
            hex_digits_next = hex_digits + 2'd1;
          end else begin
            hex_accum_next  = hex_word[11:0];
            hex_digits_next = 2'd0;
            if (mode == M_HEX1) begin
              if (hex_word[15:10] == 6'b110110) begin
                // High surrogate: a \u low surrogate must follow.
                high_surr_next = hex_word[9:0];
                mode_next      = M_BSL;
              end else if (hex_word[15:10] == 6'b110111) begin
                res_err = 1'b1;
                err_val = ERR_UNPAIRED;
              end else begin
                mode_next      = M_STR;
                hex_accum_next = 12'd0;
                res_rune       = 1'b1;
                rune_val       = {5'd0, hex_word};
              end
            end else begin
              if (hex_word[15:10] != 6'b110111) begin
                res_err = 1'b1;
                err_val = ERR_BAD_LOW;
              end else begin
                mode_next      = M_STR;
                hex_accum_next = 12'd0;
                high_surr_next = 10'd0;
                res_rune       = 1'b1;
                rune_val       = pair_rune;
              end
            end
          end
        end
        M_BSL: begin
          if (in_byte != CH_BSLASH) begin
            res_err = 1'b1;
            err_val = ERR_NO_U;
          end else begin
            mode_next = M_LU;
          end
        end
        M_LU: begin
          if (in_byte != CH_U) begin
            res_err = 1'b1;
            err_val = ERR_NO_U;
          end else begin
            mode_next       = M_HEX2;
            hex_accum_next  = 12'd0;
            hex_digits_next = 2'd0;
          end
        end
        M_IDLE: begin
          if (in_byte == CH_LF || in_byte == CH_CR || in_byte == CH_TAB ||
              in_byte == CH_SPACE) begin
            mode_next = M_IDLE;
          end else if (in_byte == CH_DQUOTE || (in_byte == CH_SQUOTE && allow_legacy)) begin
            go_idle = 1'b1;
          end else begin
            res_err = 1'b1;
            err_val = ERR_BAD_OPEN;
          end
        end
      endcase
    end

    // Errors and string ends drop all string state.
    if (res_err || go_idle || res_end) begin
      mode_next         = M_IDLE;
      quote_single_next = 1'b0;
      hex_accum_next    = 12'd0;
      hex_digits_next   = 2'd0;
      high_surr_next    = 10'd0;
      cont_left_next    = 2'd0;
    end
    // An opening quote starts a string on top of the cleared state.
    if (!end_of_input && mode == M_IDLE && !res_err &&
        (in_byte == CH_DQUOTE || (in_byte == CH_SQUOTE && allow_legacy))) begin
      mode_next         = M_STR;
      quote_single_next = (in_byte == CH_SQUOTE);
    end
  end

  // Build the result bundle, including UTF-8 encoding of a decoded code point.
  always_comb begin
    bundle          = '0;
    bundle.kind     = KIND_DATA;
    bundle.err      = ERR_NONE;
    bundle.last_idx = 2'd0;
    push            = accept && (res_err || res_end || res_byte || res_rune);
    if (res_err) begin
      bundle.kind = KIND_ERR;
      bundle.err  = err_val;
    end else if (res_end) begin
      bundle.kind = KIND_END;
    end else if (res_byte) begin
      bundle.bytes[0] = byte_val;
    end else if (res_rune) begin
      if (rune_val <= 21'h7f) begin
        bundle.bytes[0] = rune_val[7:0];
      end else if (rune_val <= 21'h7ff) begin
        bundle.last_idx = 2'd1;
        bundle.bytes[0] = {3'b110, rune_val[10:6]};
        bundle.bytes[1] = {2'b10, rune_val[5:0]};
      end else if (rune_val <= 21'hffff) begin
        bundle.last_idx = 2'd2;
        bundle.bytes[0] = {4'b1110, rune_val[15:12]};
        bundle.bytes[1] = {2'b10, rune_val[11:6]};
        bundle.bytes[2] = {2'b10, rune_val[5:0]};
      end else begin
        bundle.last_idx = 2'd3;
        bundle.bytes[0] = {5'b11110, rune_val[20:18]};
        bundle.bytes[1] = {2'b10, rune_val[17:12]};
        bundle.bytes[2] = {2'b10, rune_val[11:6]};
        bundle.bytes[3] = {2'b10, rune_val[5:0]};
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      quote_single <= 1'b0;
      hex_accum    <= 12'd0;
      hex_digits   <= 2'd0;
      high_surr    <= 10'd0;
      cont_left    <= 2'd0;
    end else if (accept) begin
      mode         <= mode_next;
      quote_single <= quote_single_next;
      hex_accum    <= hex_accum_next;
      hex_digits   <= hex_digits_next;
      high_surr    <= high_surr_next;
      cont_left    <= cont_left_next;
    end
  end

  // Only data requests carry more than one result.
  a_multi_is_data: assert property (@(posedge clk) disable iff (rst)
    push |-> (bundle.kind == KIND_DATA || bundle.last_idx == 2'd0))
    else $error("multi-result bundle that is not data");

  // An error always returns the parser to idle.
  a_err_idle: assert property (@(posedge clk) disable iff (rst)
    (push && bundle.kind == KIND_ERR) |=> mode == M_IDLE)
    else $error("parser not idle after error");

endmodule

// ----- rtl/jsu_queue.sv -----
// Short queue of result bundles between the parser and the output stage.
// Depends on jsu_pkg.
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsu_pkg::bundle_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output jsu_pkg::bundle_t head
);
  import jsu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t       store [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == FULL_CNT);
  assign valid   = (count != '0);
  assign head    = store[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Fill count never passes the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count overflow");

  // A push alone grows the count by one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ----- rtl/jsu_back.sv -----
// Output stage of the JSON string unescaper: hands out the results of the
// oldest bundle one per pop. Depends on jsu_pkg.
module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  jsu_pkg::bundle_t head,
  output logic             head_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic [3:0]       err_code,
  output logic             last
);
  import jsu_pkg::*;

  logic [1:0] idx;

  assign empty    = !head_valid;
  assign last     = (idx == head.last_idx);
  assign out_byte = head.bytes[idx];
  assign out_kind = head.kind;
  assign err_code = head.err;
  assign head_pop = pop && head_valid && last;

  // Result index within the current bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (pop && head_valid) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  // The index stays inside the current bundle.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head.last_idx)
    else $error("result index beyond bundle");

endmodule

// ----- rtl/json_string_unescaper.sv -----
// JSON string unescaper, top level.
// Input channel: push/full, one raw text byte (in_byte) or an end-of-input
// mark per request. A request is taken at an edge with push high and full
// low. The parser handles one byte per cycle while full is low.
// Result channel: empty/pop. While empty is low the oldest result is on
// out_byte, out_kind, err_code and last; pop takes it.
// The result bundle is registered in the queue; it is visible once all older
// results ahead of it have been popped.
// A \u escape can yield up to four bytes, which leave over the single result
// port at one per cycle while pop is high; the queue between parser and
// output stage (QUEUE_DEPTH bundles) absorbs these bursts and output stalls.
// full rises only when that queue is full.
// Configuration: APB register 0 (allow_legacy) at byte address 0, written
// while the block is idle. pready is always high.
// Reset (rst, synchronous) clears the queue, the parser state and
// allow_legacy; no clearing pass is needed.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
module json_string_unescaper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic [3:0]  err_code,
  output logic        last
);
  import jsu_pkg::*;

  localparam logic REG_LEGACY = 1'b0;

  logic    allow_legacy;
  logic    accept;
  logic    front_push;
  bundle_t front_bundle;
  logic    head_valid;
  logic    head_pop;
  bundle_t head;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_legacy <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_LEGACY) begin
      allow_legacy <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == REG_LEGACY) ? {31'd0, allow_legacy} : 32'd0;

  assign accept = push && !full;

  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .allow_legacy (allow_legacy),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .push         (front_push),
    .bundle       (front_bundle)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_push),
    .wr_data (front_bundle),
    .full    (full),
    .pop     (head_pop),
    .valid   (head_valid),
    .head    (head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .out_kind   (out_kind),
    .err_code   (err_code),
    .last       (last)
  );

endmodule
